FILE: rtl/cct_pkg.sv
// Shared types and constants for the client credit table.
`timescale 1ns / 1ps

package cct_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int GROUP_SIZE  = 16;
  localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [31:0] INIT_BALANCE_RESET = 32'd100;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_DUPLICATE    = 2'd1,
    ST_INSUFFICIENT = 2'd2,
    ST_FULL         = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] client_address;
    logic [31:0] request_id;
    logic [31:0] amount;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] new_balance;
  } out_item_t;

  typedef struct packed {
    logic [31:0] last_request;
    logic [31:0] balance;
  } entry_t;

  typedef struct packed {
    logic        ins;
    logic        upd;
    logic [31:0] key;
    logic [31:0] last_request;
    logic [31:0] balance;
  } wr_cmd_t;

endpackage

FILE: rtl/cct_cell.sv
// One table entry: key, last request, balance and its compare against the query.
`timescale 1ns / 1ps

module cct_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      query_key,
  input  cct_pkg::wr_cmd_t wr,
  input  logic             prev_valid,
  output logic             valid,
  output logic             hit,
  output cct_pkg::entry_t  entry
);

  logic [31:0]     key;
  cct_pkg::entry_t data;
  logic            take;

  // first free cell in the chain takes a new entry
  assign take  = wr.ins && !valid && prev_valid;
  assign entry = hit ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (take) begin
        valid <= 1'b1;
      end
      hit <= valid && (key == query_key);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key               <= wr.key;
      data.last_request <= wr.last_request;
      data.balance      <= wr.balance;
    end else if (wr.upd && hit) begin
      data.last_request <= wr.last_request;
      data.balance      <= wr.balance;
    end
  end

endmodule

FILE: rtl/cct_reduce.sv
// Two-level registered OR tree that collects the matching entry from the cell row.
`timescale 1ns / 1ps

module cct_reduce (
  input  logic            clk,
  input  logic            rst,
  input  logic            hit_vec [cct_pkg::TABLE_DEPTH],
  input  cct_pkg::entry_t entries [cct_pkg::TABLE_DEPTH],
  output logic            found,
  output cct_pkg::entry_t found_entry
);

  logic            grp_hit        [cct_pkg::NUM_GROUPS];
  cct_pkg::entry_t grp_entry      [cct_pkg::NUM_GROUPS];
  logic            grp_hit_next   [cct_pkg::NUM_GROUPS];
  cct_pkg::entry_t grp_entry_next [cct_pkg::NUM_GROUPS];
  logic            found_next;
  cct_pkg::entry_t found_entry_next;

  always_comb begin
    for (int g = 0; g < cct_pkg::NUM_GROUPS; g++) begin
      grp_hit_next[g]   = 1'b0;
      grp_entry_next[g] = '0;
      for (int j = 0; j < cct_pkg::GROUP_SIZE; j++) begin
        if (g * cct_pkg::GROUP_SIZE + j < cct_pkg::TABLE_DEPTH) begin
          grp_hit_next[g]   = grp_hit_next[g] | hit_vec[g * cct_pkg::GROUP_SIZE + j];
          grp_entry_next[g] = grp_entry_next[g] | entries[g * cct_pkg::GROUP_SIZE + j];
        end
      end
    end
  end

  always_comb begin
    found_next       = 1'b0;
    found_entry_next = '0;
    for (int g = 0; g < cct_pkg::NUM_GROUPS; g++) begin
      found_next       = found_next | grp_hit[g];
      found_entry_next = found_entry_next | grp_entry[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < cct_pkg::NUM_GROUPS; g++) begin
        grp_hit[g] <= 1'b0;
      end
      found <= 1'b0;
    end else begin
      for (int g = 0; g < cct_pkg::NUM_GROUPS; g++) begin
        grp_hit[g] <= grp_hit_next[g];
      end
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < cct_pkg::NUM_GROUPS; g++) begin
      grp_entry[g] <= grp_entry_next[g];
    end
    found_entry <= found_entry_next;
  end

endmodule

FILE: rtl/client_credit_table_with_replay_check_top.sv
// An accepted transaction passes the query register, the cell compare and two reduction stages
// to the decide step, which writes its result to the output register. One transaction at a time:
//   the input stalls through the cell compare, two reduction stages and the decide/write-back step.
// A waiting result does not block the next transaction until its decide step.
// Reset clears the entry valid bits and the fill chain at once; no clearing pass.
// initial_balance resets to 100.
`timescale 1ns / 1ps

module client_credit_table_with_replay_check_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cct_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cct_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_RED1,
    S_RED2,
    S_DECIDE
  } state_t;

  state_t             state;
  cct_pkg::in_item_t  query;
  logic [31:0]        initial_balance;

  logic               cell_valid [cct_pkg::TABLE_DEPTH];
  logic               cell_hit   [cct_pkg::TABLE_DEPTH];
  cct_pkg::entry_t    cell_entry [cct_pkg::TABLE_DEPTH];

  logic               found;
  cct_pkg::entry_t    found_entry;
  cct_pkg::wr_cmd_t   wr;
  cct_pkg::out_item_t result;
  logic               fire;
  logic               full;
  logic [31:0]        base_last;
  logic [31:0]        base_bal;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign fire      = (state == S_DECIDE) && (!out_valid || !out_stall);
  assign full      = cell_valid[cct_pkg::TABLE_DEPTH-1];

  for (genvar i = 0; i < cct_pkg::TABLE_DEPTH; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_valid = cell_valid[i-1];
    end
    cct_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .query_key  (query.client_address),
      .wr         (wr),
      .prev_valid (prev_valid),
      .valid      (cell_valid[i]),
      .hit        (cell_hit[i]),
      .entry      (cell_entry[i])
    );
  end

  cct_reduce u_reduce (
    .clk         (clk),
    .rst         (rst),
    .hit_vec     (cell_hit),
    .entries     (cell_entry),
    .found       (found),
    .found_entry (found_entry)
  );

  always_comb begin
    base_last       = found ? found_entry.last_request : '0;
    base_bal        = found ? found_entry.balance : initial_balance;
    wr.ins          = 1'b0;
    wr.upd          = 1'b0;
    wr.key          = query.client_address;
    wr.last_request = base_last;
    wr.balance      = base_bal;
    result.status      = cct_pkg::ST_ACCEPTED;
    result.new_balance = '0;
    if (!found && full) begin
      result.status = cct_pkg::ST_FULL;
    end else begin
      wr.ins = fire && !found;
      if (query.request_id <= base_last) begin
        result.status = cct_pkg::ST_DUPLICATE;
      end else if (base_bal < query.amount) begin
        result.status = cct_pkg::ST_INSUFFICIENT;
      end else begin
        wr.upd             = fire && found;
        wr.last_request    = query.request_id;
        wr.balance         = base_bal - query.amount;
        result.new_balance = base_bal - query.amount;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      initial_balance <= cct_pkg::INIT_BALANCE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        initial_balance <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK:   state <= S_RED1;
        S_RED1:   state <= S_RED2;
        S_RED2:   state <= S_DECIDE;
        S_DECIDE: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      query <= in_data;
    end
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/cct_checker.sv
// Port-level checks for the client credit table, bound to the top level.
`timescale 1ns / 1ps

module cct_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cct_pkg::out_item_t out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
    else $error("input not held off during lookup");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in flight");

  a_reject_zero_balance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != cct_pkg::ST_ACCEPTED) |-> (out_data.new_balance == '0))
    else $error("rejected transaction carries a nonzero balance");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind client_credit_table_with_replay_check_top cct_checker u_cct_checker (.*);
